>>> hw/rtl/loop_exit_value_solver_defines.svh
// ----------------------------------------------------------------------------
// loop exit value solver assertion macros
// shared property forms for the rtl checks
// ----------------------------------------------------------------------------
`ifndef LOOP_EXIT_VALUE_SOLVER_DEFINES_SVH
`define LOOP_EXIT_VALUE_SOLVER_DEFINES_SVH

// same-cycle implication
`define LEV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset
`define LEV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lev_pkg.sv
// ----------------------------------------------------------------------------
// lev_pkg
// shared types and constants of the loop exit value solver
// ----------------------------------------------------------------------------
package lev_pkg;

  localparam int LEV_DATA_WIDTH = 64;
  localparam int LEV_FIELD_W    = 64;
  localparam int LEV_OP_W       = 3;

  typedef enum logic [LEV_OP_W-1:0] {
    OP_LT = 3'd0,
    OP_LE = 3'd1,
    OP_GT = 3'd2,
    OP_GE = 3'd3,
    OP_NE = 3'd4
  } lev_op_t;

endpackage

>>> hw/rtl/lev_rem_pipe.sv
// ----------------------------------------------------------------------------
// lev_rem_pipe
// restoring remainder pipeline, one dividend bit per stage, with sideband
// ----------------------------------------------------------------------------
module lev_rem_pipe import lev_pkg::*; #(
  parameter int W      = LEV_DATA_WIDTH,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [W-1:0]      rem,
  output logic [SIDE_W-1:0] side_out
);

  logic              v    [W+1];
  logic [W-1:0]      r    [W+1];
  logic [W-1:0]      n    [W+1];
  logic [W-1:0]      d    [W+1];
  logic [SIDE_W-1:0] sd   [W+1];

  assign v[0]  = in_valid;
  assign r[0]  = '0;
  assign n[0]  = dividend;
  assign d[0]  = divisor;
  assign sd[0] = side;

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0]   shifted;
    logic [W:0]   trial;
    logic [W-1:0] r_next;

    always_comb begin
      shifted = {r[i], n[i][W-1]};
      trial   = shifted - {1'b0, d[i]};
      r_next  = trial[W] ? shifted[W-1:0] : trial[W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[i+1]  <= r_next;
        n[i+1]  <= {n[i][W-2:0], 1'b0};
        d[i+1]  <= d[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = v[W];
  assign rem       = r[W];
  assign side_out  = sd[W];

endmodule

>>> hw/rtl/loop_exit_value_solver.sv
// ----------------------------------------------------------------------------
// loop_exit_value_solver
// closed-form exit value of "while (var op limit) var += step"
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with opcode, start_value, limit_value,
// step_value; output channel: out_valid / out_stall with terminates and
// final_value. one result transaction per input transaction, in order.
// the pipeline is one decode stage, DATA_WIDTH stages of the restoring
// remainder pipeline (one dividend bit each) and one result stage.
// throughput is one transaction per cycle while out_stall does not hold the
// pipeline; the remainder pipeline sets the depth. the trip-count product is
// rebuilt from dividend, remainder and divisor, so no multiplier is needed.
// reset clears all stage valid bits; no transaction is in flight after it.
// while a result waits under out_stall, the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "loop_exit_value_solver_defines.svh"

module loop_exit_value_solver import lev_pkg::*; #(
  parameter int DATA_WIDTH = LEV_DATA_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [LEV_OP_W-1:0]    opcode,
  input  logic [LEV_FIELD_W-1:0] start_value,
  input  logic [LEV_FIELD_W-1:0] limit_value,
  input  logic [LEV_FIELD_W-1:0] step_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   terminates,
  output logic [LEV_FIELD_W-1:0] final_value
);

  localparam int W = DATA_WIDTH;

  typedef struct packed {
    logic [LEV_OP_W-1:0] op;
    logic                need;
    logic                term;
    logic                down;
    logic [W-1:0]        s;
    logic [W-1:0]        l;
    logic [W-1:0]        mag;
    logic [W-1:0]        span;
  } side_t;

  logic   en;
  side_t  dec;
  side_t  side0;
  logic   v0;
  logic   div_valid;
  logic [W-1:0] div_rem;
  side_t  div_side;
  logic   term_next;
  logic [W-1:0] fin_next;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // decode stage
  always_comb begin
    logic [W-1:0] s, l, d;
    logic lt_sl, lt_ls, holds, toward;
    s = start_value[W-1:0];
    l = limit_value[W-1:0];
    d = step_value[W-1:0];
    lt_sl = $signed(s) < $signed(l);
    lt_ls = $signed(l) < $signed(s);
    unique case (lev_op_t'(opcode))
      OP_LT:   holds = lt_sl;
      OP_LE:   holds = !lt_ls;
      OP_GT:   holds = lt_ls;
      OP_GE:   holds = !lt_sl;
      OP_NE:   holds = (s != l);
      default: holds = 1'b0;
    endcase
    dec.op   = opcode;
    dec.down = d[W-1];
    dec.mag  = d[W-1] ? (W'(0) - d) : d;
    if (lev_op_t'(opcode) == OP_NE) begin
      toward = d[W-1] ? lt_ls : lt_sl;
    end else begin
      toward = d[W-1] ? (lev_op_t'(opcode) == OP_GT || lev_op_t'(opcode) == OP_GE)
                      : (lev_op_t'(opcode) == OP_LT || lev_op_t'(opcode) == OP_LE);
    end
    dec.span = d[W-1] ? (s - l) : (l - s);
    dec.need = holds && (d != '0) && toward;
    dec.term = !holds;
    dec.s    = s;
    dec.l    = l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0 <= dec;
    end
  end

  lev_rem_pipe #(
    .W      (W),
    .SIDE_W ($bits(side_t))
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .dividend  (side0.span),
    .divisor   (side0.mag),
    .side      (side0),
    .out_valid (div_valid),
    .rem       (div_rem),
    .side_out  (div_side)
  );

  // result stage
  always_comb begin
    logic [W-1:0] prod;
    logic strict;
    strict    = (lev_op_t'(div_side.op) == OP_LT) || (lev_op_t'(div_side.op) == OP_GT);
    prod      = (strict && div_rem == '0) ? div_side.span
                                          : (div_side.span - div_rem + div_side.mag);
    term_next = div_side.term;
    fin_next  = div_side.s;
    if (div_side.need) begin
      if (lev_op_t'(div_side.op) == OP_NE) begin
        if (div_rem == '0) begin
          term_next = 1'b1;
          fin_next  = div_side.l;
        end
      end else begin
        term_next = 1'b1;
        fin_next  = div_side.down ? (div_side.s - prod) : (div_side.s + prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      terminates  <= term_next;
      final_value <= LEV_FIELD_W'($signed(fin_next));
    end
  end

  `LEV_ASSERT_NOW(a_rem_below_divisor, div_valid && div_side.need, div_rem < div_side.mag,
    "remainder not below divisor")
  `LEV_ASSERT_NOW(a_divisor_nonzero, v0 && side0.need, side0.mag != '0,
    "division issued with zero divisor")
  `LEV_ASSERT_NEXT(a_reset_clears_out, rst, !out_valid,
    "output valid after reset")

endmodule
